@@ sv/spq_pkg.sv @@
package spq_pkg;

  localparam int VALUE_W    = 32;
  localparam int PRI_REQ_W  = 7;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                        command;
    logic signed [VALUE_W-1:0]   value;
    logic        [PRI_REQ_W-1:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    status_t                   status;
    logic signed [VALUE_W-1:0] head_value;
    logic        [COUNT_W-1:0] entry_count;
  } spq_rsp_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_flags_t;

endpackage

@@ sv/spq_ctrl.sv @@
module spq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  spq_pkg::spq_flags_t flags,
  output spq_pkg::spq_cmd_t   cmd,
  output logic                busy,
  output logic                done,
  output spq_pkg::status_t    status
);
  import spq_pkg::*;

  typedef enum logic {
    ST_BOOT,
    ST_RUN
  } state_t;

  state_t  state;
  status_t status_next;
  logic    accept;

  assign busy   = (state == ST_BOOT);
  assign accept = start && !busy;

  always_comb begin
    cmd.load    = accept;
    cmd.push    = 1'b0;
    cmd.pop     = 1'b0;
    status_next = STATUS_OK;
    if (command == CMD_PUSH) begin
      if (flags.full) begin
        status_next = STATUS_FULL;
      end else begin
        cmd.push = accept;
      end
    end else begin
      if (flags.empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        cmd.pop = accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_BOOT;
      done   <= 1'b0;
      status <= STATUS_OK;
    end else begin
      case (state)
        ST_BOOT: state <= ST_RUN;
        ST_RUN:  state <= ST_RUN;
        default: state <= ST_BOOT;
      endcase
      done <= accept;
      if (accept) begin
        status <= status_next;
      end
    end
  end

endmodule

@@ sv/spq_datapath.sv @@
module spq_datapath #(
  parameter int CAPACITY        = 16,
  parameter int PRIORITY_LEVELS = 100,
  parameter int VALUE_BITS      = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::spq_cmd_t               cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0]   value,
  input  logic        [spq_pkg::PRI_REQ_W-1:0] priority_req,
  output spq_pkg::spq_flags_t             flags,
  output logic signed [spq_pkg::VALUE_W-1:0]   popped_value,
  output logic signed [spq_pkg::VALUE_W-1:0]   head_value,
  output logic        [spq_pkg::COUNT_W-1:0]   entry_count
);
  import spq_pkg::*;

  localparam int PRI_W      = (PRIORITY_LEVELS > 2) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int STORE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PRI_EXT_W  = PRI_REQ_W + 2;

  logic [PRI_W-1:0]      slot_priority [CAPACITY];
  logic [STORE_BITS-1:0] slot_value    [CAPACITY];
  logic [CNT_W-1:0]      occupancy;
  logic [STORE_BITS-1:0] popped;

  logic [PRI_EXT_W-1:0]  pri_ext;
  logic [PRI_W-1:0]      pri_sat;
  logic [STORE_BITS-1:0] value_in;
  logic [CAPACITY-1:0]   later;

  assign pri_ext  = PRI_EXT_W'(priority_req);
  assign pri_sat  = (pri_ext >= PRI_EXT_W'(PRIORITY_LEVELS)) ?
                    PRI_W'(PRIORITY_LEVELS - 1) : PRI_W'(pri_ext);
  assign value_in = STORE_BITS'(value);

  // a cell is "later" when it is empty or holds a strictly higher priority
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  prev_later;
    logic [PRI_W-1:0]      down_pri;
    logic [STORE_BITS-1:0] down_val;
    logic [PRI_W-1:0]      up_pri;
    logic [STORE_BITS-1:0] up_val;

    assign later[i] = (CNT_W'(i) >= occupancy) || (slot_priority[i] > pri_sat);

    if (i == 0) begin : g_first
      assign prev_later = 1'b0;
      assign down_pri   = slot_priority[i];
      assign down_val   = slot_value[i];
    end else begin : g_rest
      assign prev_later = later[i-1];
      assign down_pri   = slot_priority[i-1];
      assign down_val   = slot_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign up_pri = slot_priority[i];
      assign up_val = slot_value[i];
    end else begin : g_inner
      assign up_pri = slot_priority[i+1];
      assign up_val = slot_value[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.push) begin
        if (later[i]) begin
          if (prev_later) begin
            slot_priority[i] <= down_pri;
            slot_value[i]    <= down_val;
          end else begin
            slot_priority[i] <= pri_sat;
            slot_value[i]    <= value_in;
          end
        end
      end else if (cmd.pop) begin
        slot_priority[i] <= up_pri;
        slot_value[i]    <= up_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.push) begin
      occupancy <= occupancy + CNT_W'(1);
    end else if (cmd.pop) begin
      occupancy <= occupancy - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped <= cmd.pop ? slot_value[0] : '0;
    end
  end

  assign flags.full   = (occupancy == CNT_W'(CAPACITY));
  assign flags.empty  = (occupancy == '0);
  assign popped_value = VALUE_W'(popped);
  assign head_value   = flags.empty ? '0 : VALUE_W'(slot_value[0]);
  assign entry_count  = COUNT_W'(occupancy);

endmodule

@@ sv/stable_priority_queue.sv @@
// channel   | ports                    | transaction
// ----------+--------------------------+-----------------------------------
// command   | start, busy, req         | start high and busy low at the edge
// result    | done, rsp                | done high for one cycle
//
// One command per cycle while busy is low: a command taken at one edge gives its result in
// the next cycle, with done high; a new command may be taken in that cycle.
// Insertion runs in parallel across the sorted row of slot registers.
// Synchronous reset empties the queue; busy is high for one cycle after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module stable_priority_queue #(
  parameter int CAPACITY        = 16,
  parameter int PRIORITY_LEVELS = 100,
  parameter int VALUE_BITS      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t req,
  output logic              done,
  output spq_pkg::spq_rsp_t rsp
);
  import spq_pkg::*;

  spq_cmd_t   cmd;
  spq_flags_t flags;
  status_t    status;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (req.command),
    .flags   (flags),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .status  (status)
  );

  spq_datapath #(
    .CAPACITY        (CAPACITY),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .VALUE_BITS      (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (req.value),
    .priority_req (req.priority_req),
    .flags        (flags),
    .popped_value (rsp.popped_value),
    .head_value   (rsp.head_value),
    .entry_count  (rsp.entry_count)
  );

  assign rsp.status = status;

`ifndef NO_ASSERTIONS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a taken command");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_EMPTY) |->
      (rsp.entry_count == '0 && rsp.popped_value == '0 && rsp.head_value == '0))
    else $error("empty pop result inconsistent");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_FULL) |-> rsp.entry_count == COUNT_W'(CAPACITY))
    else $error("dropped push while not full");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_OK && $past(req.command) == CMD_POP) |->
      rsp.entry_count == $past(rsp.entry_count) - COUNT_W'(1))
    else $error("pop did not remove one entry");
`endif

endmodule
